FILE: rtl/core/spp_pkg.sv
package spp_pkg;

  localparam int SPP_COORD_WIDTH = 32;

endpackage

FILE: rtl/core/sphere_pair_penetration.sv
// Throughput: one sphere pair per cycle. The square root takes one bit per stage and
// each divider one quotient bit per stage, so no unit is shared between items.
// A stalled output holds the whole pipeline in place.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
module sphere_pair_penetration #(
  parameter int COORD_WIDTH = spp_pkg::SPP_COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // center_a_x, center_a_y, center_a_z, radius_a, picked_a,
  // center_b_x, center_b_y, center_b_z, radius_b, picked_b
  input  logic [8*COORD_WIDTH-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit, push_x, push_y, push_z, recolor_a, recolor_b, zero fill
  output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] m_tdata
);
  import spp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NB = CW + 1;          // root and quotient bits
  localparam int SW = 2*CW + 3;        // sqrt remainder width
  localparam int OW = ((3*CW+3+7)/8)*8;

  typedef struct packed {
    logic [2:0][CW:0] mag;
    logic [2:0]       neg;
    logic [CW-1:0]    rs;
    logic             pa;
    logic             pb;
  } carry_t;

  typedef struct packed {
    logic [2:0][CW:0] rem;
    logic [2:0][CW:0] lo;
    logic [2:0][CW:0] q;
    logic [2:0]       ovf;
    logic [2:0]       neg;
    logic [CW:0]      len;
    logic             hit;
    logic             lz;
    logic             pa;
    logic             pb;
  } div_t;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: center differences and radius sum
  logic v1;
  carry_t c1;
  logic [2:0][CW-1:0] ca, cb;
  logic [CW-2:0] ra, rb;
  assign ca[0] = s_tdata[CW-1:0];
  assign ca[1] = s_tdata[2*CW-1:CW];
  assign ca[2] = s_tdata[3*CW-1:2*CW];
  assign ra    = s_tdata[4*CW-2:3*CW];
  assign cb[0] = s_tdata[5*CW-1:4*CW];
  assign cb[1] = s_tdata[6*CW-1:5*CW];
  assign cb[2] = s_tdata[7*CW-1:6*CW];
  assign rb    = s_tdata[8*CW-2:7*CW];

  carry_t c1_next;
  always_comb begin
    logic [CW:0] d;
    c1_next = '0;
    for (int i = 0; i < 3; i++) begin
      d = {ca[i][CW-1], ca[i]} - {cb[i][CW-1], cb[i]};
      c1_next.neg[i] = d[CW];
      c1_next.mag[i] = d[CW] ? (~d + 1'b1) : d;
    end
    c1_next.rs = {1'b0, ra} + {1'b0, rb};
    c1_next.pa = s_tdata[4*CW-1];
    c1_next.pb = s_tdata[8*CW-1];
  end

  // stage 2: squares, stage 3: sum
  logic v2, v3;
  carry_t c2, c3;
  logic [2:0][2*CW+1:0] sq2;
  logic [SW-1:0] s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      c1 <= c1_next;
      c2 <= c1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= c1.mag[i] * c1.mag[i];
      end
      c3 <= c2;
      s3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
    end
  end

  // square root, one root bit per stage, MSB first
  logic   [NB-1:0]        qv;
  carry_t [NB-1:0]        qc;
  logic   [NB-1:0][SW-1:0] qrem;
  logic   [NB-1:0][CW:0]   qroot;

  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    localparam int K = CW - j;
    logic [SW-1:0] rem_in, trial;
    logic [CW:0]   root_in;
    logic          v_in;
    carry_t        c_in;
    if (j == 0) begin : g_first
      assign rem_in  = s3;
      assign root_in = '0;
      assign v_in    = v3;
      assign c_in    = c3;
    end else begin : g_rest
      assign rem_in  = qrem[j-1];
      assign root_in = qroot[j-1];
      assign v_in    = qv[j-1];
      assign c_in    = qc[j-1];
    end
    assign trial = (SW'(root_in) << (K+1)) | (SW'(1) << (2*K));

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[j] <= 1'b0;
      end else if (en) begin
        qv[j] <= v_in;
      end
      if (en) begin
        qc[j] <= c_in;
        if (rem_in >= trial) begin
          qrem[j]  <= rem_in - trial;
          qroot[j] <= root_in | ((CW+1)'(1) << K);
        end else begin
          qrem[j]  <= rem_in;
          qroot[j] <= root_in;
        end
      end
    end
  end

  // stage 4: hit test and overlap, stage 5: overlap products, stage 6: divider setup
  logic v4, v5, v6;
  carry_t c4, c5;
  logic [CW:0] len4, len5;
  logic [CW-1:0] ovl4;
  logic hit4, lz4, hit5, lz5;
  logic [2:0][2*CW+1:0] num5;
  div_t d6;
  logic [CW:0] len_w;
  assign len_w = qroot[NB-1];

  div_t d6_next;
  always_comb begin
    logic [CW:0] hi_part;
    d6_next = '0;
    for (int i = 0; i < 3; i++) begin
      hi_part = num5[i][2*CW+1:CW+1];
      d6_next.ovf[i] = hi_part >= len5;
      d6_next.rem[i] = hi_part;
      d6_next.lo[i]  = num5[i][CW:0];
    end
    d6_next.neg = c5.neg;
    d6_next.len = len5;
    d6_next.hit = hit5;
    d6_next.lz  = lz5;
    d6_next.pa  = c5.pa;
    d6_next.pb  = c5.pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= qv[NB-1];
      v5 <= v4;
      v6 <= v5;
    end
    if (en) begin
      c4   <= qc[NB-1];
      len4 <= len_w;
      hit4 <= len_w < {1'b0, qc[NB-1].rs};
      lz4  <= len_w == '0;
      ovl4 <= qc[NB-1].rs - len_w[CW-1:0];
      c5   <= c4;
      len5 <= len4;
      hit5 <= hit4;
      lz5  <= lz4;
      for (int i = 0; i < 3; i++) begin
        num5[i] <= (2*CW+2)'(c4.mag[i] * ovl4);
      end
      d6 <= d6_next;
    end
  end

  // restoring dividers, one quotient bit per stage, MSB first
  logic [NB-1:0] dv;
  div_t [NB-1:0] dd;

  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int K = CW - j;
    div_t d_in, d_out;
    logic v_in;
    if (j == 0) begin : g_first
      assign d_in = d6;
      assign v_in = v6;
    end else begin : g_rest
      assign d_in = dd[j-1];
      assign v_in = dv[j-1];
    end

    always_comb begin
      logic [CW+1:0] r2;
      d_out = d_in;
      for (int i = 0; i < 3; i++) begin
        r2 = {d_in.rem[i], d_in.lo[i][K]};
        if (r2 >= {1'b0, d_in.len}) begin
          r2 = r2 - {1'b0, d_in.len};
          d_out.q[i][K] = 1'b1;
        end
        d_out.rem[i] = r2[CW:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= v_in;
      end
      if (en) begin
        dd[j] <= d_out;
      end
    end
  end

  // output stage: sign, saturation, packing
  div_t df;
  logic [OW-1:0] out_next;
  assign df = dd[NB-1];

  always_comb begin
    logic [CW:0] lim;
    logic [CW:0] m;
    logic [CW-1:0] p;
    lim = (CW+1)'(1) << (CW-1);
    out_next = '0;
    out_next[0] = df.hit;
    for (int i = 0; i < 3; i++) begin
      m = df.q[i];
      if (df.neg[i]) begin
        if (df.ovf[i] || m > lim) begin
          m = lim;
        end
        p = CW'(~m + 1'b1);
      end else begin
        if (df.ovf[i] || m > lim - 1'b1) begin
          m = lim - 1'b1;
        end
        p = m[CW-1:0];
      end
      if (!df.hit || df.lz) begin
        p = '0;
      end
      out_next[1+i*CW +: CW] = p;
    end
    out_next[3*CW+1] = df.hit && !df.pa;
    out_next[3*CW+2] = df.hit && !df.pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[NB-1];
    end
    if (en) begin
      m_tdata <= out_next;
    end
  end

endmodule

FILE: tb/sv/tb_sphere_pair_penetration.sv
`timescale 1ns / 100ps

module tb_sphere_pair_penetration;
  import spp_pkg::*;

  localparam int CW = SPP_COORD_WIDTH;
  localparam int OW = ((3*CW+3+7)/8)*8;
  localparam int LAT = 2*CW+9;

  typedef struct {
    logic signed [CW-1:0] ax, ay, az;
    logic [CW-2:0]        ra;
    logic                 pa;
    logic signed [CW-1:0] bx, by, bz;
    logic [CW-2:0]        rb;
    logic                 pb;
  } pair_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] px, py, pz;
    logic                 rca, rcb;
  } push_t;

  class contact_board;
    push_t pending[$];
    int    errors;

    function push_t predict(pair_t p);
      logic [127:0] mag[3];
      logic         neg[3];
      logic [127:0] s, len, c, rsum, q, lim;
      longint       d;
      push_t        r;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        case (i)
          0: d = longint'(p.ax) - longint'(p.bx);
          1: d = longint'(p.ay) - longint'(p.by);
          default: d = longint'(p.az) - longint'(p.bz);
        endcase
        neg[i] = d < 0;
        mag[i] = neg[i] ? 128'(-d) : 128'(d);
        s += mag[i] * mag[i];
      end
      len = 0;
      for (int b = 63; b >= 0; b--) begin
        c = len | (128'd1 << b);
        if (c * c <= s) len = c;
      end
      rsum = 128'(p.ra) + 128'(p.rb);
      r.hit = len < rsum;
      lim = 128'd1 << (CW-1);
      for (int i = 0; i < 3; i++) begin
        q = 0;
        // coincident centers: hit with a zero push
        if (r.hit && len != 0) begin
          q = mag[i] * (rsum - len) / len;
          if (neg[i]) begin
            if (q > lim) q = lim;
            q = -q;
          end else if (q > lim - 1) q = lim - 1;
        end
        case (i)
          0: r.px = q[CW-1:0];
          1: r.py = q[CW-1:0];
          default: r.pz = q[CW-1:0];
        endcase
      end
      r.rca = r.hit && !p.pa;
      r.rcb = r.hit && !p.pb;
      return r;
    endfunction

    function void note(pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check(push_t got);
      push_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b", $time, got.hit);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit exp %0b got %0b", $time, e.hit, got.hit); errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: push_x exp %0d got %0d", $time, e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: push_y exp %0d got %0d", $time, e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
        $display("%0t: push_z exp %0d got %0d", $time, e.pz, got.pz); errors++;
      end
      if (got.rca !== e.rca) begin
        $display("%0t: recolor_a exp %0b got %0b", $time, e.rca, got.rca); errors++;
      end
      if (got.rcb !== e.rcb) begin
        $display("%0t: recolor_b exp %0b got %0b", $time, e.rcb, got.rcb); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [8*CW-1:0] s_tdata;
  logic [OW-1:0]   m_tdata;
  logic            calm;

  contact_board sb;

  sphere_pair_penetration dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("sphere_pair_penetration regression: fail");
    $finish;
  end

  task automatic send_pair(pair_t p);
    s_tvalid <= 1'b1;
    s_tdata  <= {p.pb, p.rb, p.bz, p.by, p.bx, p.pa, p.ra, p.az, p.ay, p.ax};
    do @(posedge clk); while (!s_tready);
    sb.note(p);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic pair_t mk(int ax, int ay, int az, int ra, bit pa,
                               int bx, int by, int bz, int rb, bit pb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.ra = ra[CW-2:0]; p.pa = pa;
    p.bx = bx; p.by = by; p.bz = bz; p.rb = rb[CW-2:0]; p.pb = pb;
    return p;
  endfunction

  function automatic int near_delta();
    int w;
    w = 1 << $urandom_range(0, 30);
    return int'($urandom_range(0, w)) - int'($urandom_range(0, w));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int sc;
    p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
    p.pa = $urandom; p.pb = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
      p.ra = $urandom; p.rb = $urandom;
    end else begin
      // nearby spheres so most pairs touch
      p.bx = p.ax + near_delta(); p.by = p.ay + near_delta(); p.bz = p.az + near_delta();
      sc = $urandom_range(0, 30);
      p.ra = $urandom_range(0, (1 << sc)); p.rb = $urandom_range(0, (1 << sc));
      if ($urandom_range(0, 9) == 0) p.ra = $urandom;
    end
    return p;
  endfunction

  // result side: stall bursts
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check('{hit: m_tdata[0], px: m_tdata[CW:1], py: m_tdata[2*CW:CW+1],
                 pz: m_tdata[3*CW:2*CW+1], rca: m_tdata[3*CW+1],
                 rcb: m_tdata[3*CW+2]});

  initial begin
    pair_t dir[$];
    int    wait_cnt;
    sb = new();
    calm = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));               // zero radius sum, no hit
    dir.push_back(mk(5, -7, 9, 1, 0, 5, -7, 9, 0, 1));             // coincident centers
    dir.push_back(mk(0, 0, 0, 1, 1, 0, 0, 0, 1, 1));               // coincident, both picked
    dir.push_back(mk(100, 0, 0, 50, 0, 0, 0, 0, 50, 0));           // touching exactly
    dir.push_back(mk(100, 0, 0, 51, 0, 0, 0, 0, 50, 1));           // just overlapping
    dir.push_back(mk(3, 4, 0, 10, 1, 0, 0, 0, 10, 0));
    dir.push_back(mk(-3, -4, -12, 20, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(1, 0, 0, 'h7fffffff, 0, 0, 0, 0, 'h7fffffff, 0)); // saturate positive
    dir.push_back(mk(-1, 0, 0, 'h7fffffff, 0, 0, 0, 0, 'h7fffffff, 1)); // saturate negative
    dir.push_back(mk(0, 1, -1, 'h7fffffff, 1, 0, 0, 0, 'h7fffffff, 0));
    dir.push_back(mk('h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 0,
                     'h80000000, 'h80000000, 'h80000000, 'h7fffffff, 0)); // widest gap
    dir.push_back(mk('h80000000, 'h80000000, 'h80000000, 'h7fffffff, 1,
                     'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff, 1));
    dir.push_back(mk('h80000000, 0, 0, 'h7fffffff, 0, 'h7fffffff, 0, 0, 'h7fffffff, 0));
    dir.push_back(mk(-1, -1, -1, 'h7fffffff, 0, -1, -1, -1, 'h7fffffff, 0));
    dir.push_back(mk(0, 'h10000, 0, 'h8000, 0, 0, 0, 0, 'h8000, 0));
    dir.push_back(mk(0, 'h10000, 0, 'h8000, 1, 0, 0, 0, 'h8001, 0));
    foreach (dir[i]) begin
      send_pair(dir[i]);
      sender_gap();
    end

    for (int n = 0; n < 1750; n++) begin
      if (n == 1500) calm = 1'b1;
      if (n == 700) begin
        // hold off until the pipeline drains
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      send_pair(rand_pair());
      sender_gap();
    end
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT + 20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("sphere_pair_penetration regression: pass");
    else
      $display("sphere_pair_penetration regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/spp_pkg.sv
rtl/core/sphere_pair_penetration.sv
tb/sv/tb_sphere_pair_penetration.sv
